// ===== src/rtob_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtob_pkg
// Shared types and codes of the ring total-order broadcast node.
// ----------------------------------------------------------------------------
package rtob_pkg;

  localparam int DEF_MAX_SITES   = 16;
  localparam int DEF_QUEUE_DEPTH = 32;

  localparam int RANK_W  = 4;
  localparam int CLK_W   = 32;
  localparam int PAY_W   = 32;
  localparam int SC_W    = 5;
  localparam int ACT_W   = 2;
  localparam int KIND_W  = 2;
  localparam int TDATA_W = 72;

  localparam logic [ACT_W-1:0] ACT_LOCAL = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DATA  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ACK   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd3;

  localparam logic REG_SITE_COUNT = 1'b0;
  localparam logic REG_OWN_RANK   = 1'b1;

  typedef struct packed {
    logic [RANK_W-1:0] origin;
    logic [CLK_W-1:0]  clock;
    logic [PAY_W-1:0]  payload;
  } q_entry_t;

endpackage

// ===== src/rtob_clock_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtob_clock_ram
// Per-site clock memory, one read and one write port, registered read.
// Entries not yet written read as zero.
// ----------------------------------------------------------------------------
module rtob_clock_ram import rtob_pkg::*; #(
  parameter int MAX_SITES = DEF_MAX_SITES,
  localparam int AW = $clog2(MAX_SITES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [CLK_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [CLK_W-1:0] wr_data
);

  logic [CLK_W-1:0]     mem [MAX_SITES];
  logic [MAX_SITES-1:0] vld;
  logic [CLK_W-1:0]     rd_raw;
  logic                 rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

// ===== src/rtob_queue_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtob_queue_ram
// Pending message store, one read and one write port, registered read.
// ----------------------------------------------------------------------------
module rtob_queue_ram import rtob_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  localparam int AW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output q_entry_t      rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  q_entry_t      wr_data
);

  q_entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/ring_total_order_broadcast_node.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_total_order_broadcast_node
// One node of a ring total-order broadcast with a clock vector and a queue.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser carries the action, tdata the message fields.
// Output stream m_*: tuser carries the result kind, tdata the message
// fields, tlast marks the final result of one input item.
// Configuration: cfg_we, cfg_index, cfg_data write site_count or own_rank;
// a write starts a small iterative unit that works out the next site,
// and input is held off until it finishes.
// One item at a time: a refusal, a local broadcast or a forwarded data
// message is finished before the next item is taken. An ack scans the
// queue one entry per cycle through the single queue read port, then
// delivers the run of stable entries at the head of the queue.
// Reset clears the clocks (valid bits), the stable marks, head and fill;
// site_count resets to 1 and own_rank to 0.
// A stalled receiver holds the output register; the node waits with it
// and loses nothing. The next item is taken while the last result waits.
// ----------------------------------------------------------------------------
module ring_total_order_broadcast_node import rtob_pkg::*; #(
  parameter int MAX_SITES   = DEF_MAX_SITES,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // sender_rank[3:0], msg_clock[35:4], payload[67:36], zero[71:68]
  input  logic [TDATA_W-1:0] s_tdata,
  // action[1:0]
  input  logic [ACT_W-1:0]   s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // origin_rank[3:0], out_clock[35:4], out_payload[67:36], zero[71:68]
  output logic [TDATA_W-1:0] m_tdata,
  // result_kind[1:0]
  output logic [KIND_W-1:0]  m_tuser,
  output logic               m_tlast,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [SC_W-1:0]    cfg_data
);

  localparam int SAW = $clog2(MAX_SITES);
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CLK       = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_DRAIN_RD  = 3'd3;
  localparam logic [2:0] S_DRAIN_OUT = 3'd4;
  localparam logic [2:0] S_EMIT      = 3'd5;

  logic [2:0]             state;
  logic [SC_W-1:0]        site_count;
  logic [RANK_W-1:0]      own_rank;
  logic                   mod_busy;
  logic                   mod_init;
  logic [SC_W-1:0]        mod_val;
  logic [SC_W-1:0]        site_n;

  logic [ACT_W-1:0]       a_action;
  logic [RANK_W-1:0]      a_sender;
  logic [CLK_W-1:0]       a_clock;
  logic [PAY_W-1:0]       a_payload;
  logic [RANK_W-1:0]      a_rank;
  logic                   a_rank_ok;

  logic [QAW-1:0]         head;
  logic [FW-1:0]          fill;
  logic [QUEUE_DEPTH-1:0] stable;
  logic [QAW-1:0]         scan_slot;
  logic [FW-1:0]          scan_cnt;

  logic [KIND_W-1:0]      res_kind;
  logic [RANK_W-1:0]      res_origin;
  logic [CLK_W-1:0]       res_clock;
  logic [PAY_W-1:0]       res_payload;

  logic                   accept;
  logic                   out_free;
  logic                   m_load;
  logic                   full;
  logic [RANK_W-1:0]      in_sender;
  logic [CLK_W-1:0]       in_clock;
  logic [PAY_W-1:0]       in_payload;
  logic [QAW:0]           tail_sum;
  logic [QAW-1:0]         tail;
  logic [QAW-1:0]         head_inc;
  logic [QAW-1:0]         scan_inc;
  logic                   done;
  logic [CLK_W-1:0]       new_clock;
  logic [CLK_W-1:0]       push_clock;

  logic                   crd_en;
  logic [SAW-1:0]         crd_addr;
  logic [CLK_W-1:0]       crd_data;
  logic                   cwr_en;
  logic                   qrd_en;
  logic [QAW-1:0]         qrd_addr;
  q_entry_t               qrd_data;
  logic                   qwr_en;
  q_entry_t               qwr_data;

  assign in_sender  = s_tdata[3:0];
  assign in_clock   = s_tdata[35:4];
  assign in_payload = s_tdata[67:36];

  assign s_tready = (state == S_IDLE) && !mod_busy;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_load   = out_free && (state == S_DRAIN_OUT || state == S_EMIT);
  assign full     = (fill == FW'(QUEUE_DEPTH));

  assign tail_sum = {1'b0, head} + (QAW+1)'(fill);
  assign tail     = (tail_sum >= (QAW+1)'(QUEUE_DEPTH))
                    ? QAW'(tail_sum - (QAW+1)'(QUEUE_DEPTH)) : QAW'(tail_sum);
  assign head_inc = (head == QAW'(QUEUE_DEPTH - 1)) ? '0 : QAW'(head + 1'b1);
  assign scan_inc = (scan_slot == QAW'(QUEUE_DEPTH - 1)) ? '0
                    : QAW'(scan_slot + 1'b1);

  assign site_n = (site_count == '0) ? SC_W'(1)
                : ({2'b00, site_count} > 7'(MAX_SITES)) ? SC_W'(MAX_SITES) : site_count;

  assign done       = (a_action == ACT_DATA) && (mod_val == {1'b0, a_sender});
  assign new_clock  = crd_data + 1'b1;
  assign push_clock = (a_action == ACT_LOCAL) ? (a_rank_ok ? new_clock : '0) : a_clock;

  // next site = (own_rank + 1) mod site count clamped to 1..MAX_SITES, by repeated subtraction
  always_ff @(posedge clk) begin
    if (rst) begin
      site_count <= SC_W'(1);
      own_rank   <= '0;
      mod_busy   <= 1'b0;
      mod_init   <= 1'b0;
      mod_val    <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SITE_COUNT) begin
          site_count <= cfg_data;
        end else begin
          own_rank <= cfg_data[RANK_W-1:0];
        end
        mod_busy <= 1'b1;
        mod_init <= 1'b1;
      end else if (mod_busy) begin
        if (mod_init) begin
          mod_val  <= {1'b0, own_rank} + SC_W'(1);
          mod_init <= 1'b0;
        end else if (mod_val >= site_n) begin
          mod_val <= mod_val - site_n;
        end else begin
          mod_busy <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    crd_en   = 1'b0;
    crd_addr = SAW'(in_sender);
    qrd_en   = 1'b0;
    qrd_addr = head;
    case (state)
      S_IDLE: begin
        if (accept) begin
          crd_en   = (s_tuser == ACT_LOCAL || s_tuser == ACT_DATA) && !full;
          crd_addr = (s_tuser == ACT_LOCAL) ? SAW'(own_rank) : SAW'(in_sender);
          qrd_en   = (s_tuser == ACT_ACK);
        end
      end
      S_SCAN: begin
        qrd_en   = 1'b1;
        qrd_addr = scan_inc;
      end
      S_DRAIN_RD: begin
        qrd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign cwr_en   = (state == S_CLK) && a_rank_ok;
  assign qwr_en   = (state == S_CLK);
  assign qwr_data = '{origin: a_rank, clock: push_clock, payload: a_payload};

  rtob_clock_ram #(.MAX_SITES(MAX_SITES)) u_clock_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (crd_en),
    .rd_addr (crd_addr),
    .rd_data (crd_data),
    .wr_en   (cwr_en),
    .wr_addr (SAW'(a_rank)),
    .wr_data (new_clock)
  );

  rtob_queue_ram #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk     (clk),
    .rd_en   (qrd_en),
    .rd_addr (qrd_addr),
    .rd_data (qrd_data),
    .wr_en   (qwr_en),
    .wr_addr (tail),
    .wr_data (qwr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      fill     <= '0;
      stable   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            a_action  <= s_tuser;
            a_sender  <= in_sender;
            a_clock   <= in_clock;
            a_payload <= in_payload;
            case (s_tuser)
              ACT_LOCAL: begin
                a_rank    <= own_rank;
                a_rank_ok <= ({3'b000, own_rank} < 7'(MAX_SITES));
                if (full) begin
                  res_kind    <= KIND_REFUSED;
                  res_origin  <= own_rank;
                  res_clock   <= '0;
                  res_payload <= in_payload;
                  state       <= S_EMIT;
                end else begin
                  state <= S_CLK;
                end
              end
              ACT_DATA: begin
                a_rank    <= in_sender;
                a_rank_ok <= ({3'b000, in_sender} < 7'(MAX_SITES));
                if (full) begin
                  res_kind    <= KIND_REFUSED;
                  res_origin  <= in_sender;
                  res_clock   <= in_clock;
                  res_payload <= in_payload;
                  state       <= S_EMIT;
                end else begin
                  state <= S_CLK;
                end
              end
              ACT_ACK: begin
                res_kind    <= KIND_ACK;
                res_origin  <= in_sender;
                res_clock   <= in_clock;
                res_payload <= in_payload;
                scan_slot   <= head;
                scan_cnt    <= '0;
                if (mod_val == {1'b0, in_sender}) begin
                  state <= S_IDLE;
                end else if (fill == '0) begin
                  state <= S_EMIT;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_CLK: begin
          stable[tail] <= done;
          fill         <= fill + 1'b1;
          res_kind     <= done ? KIND_ACK : KIND_DATA;
          res_origin   <= a_rank;
          res_clock    <= push_clock;
          res_payload  <= a_payload;
          if (done) begin
            state <= S_DRAIN_RD;
          end else begin
            state <= S_EMIT;
          end
        end
        S_SCAN: begin
          if (qrd_data.clock == a_clock && qrd_data.origin == a_sender) begin
            stable[scan_slot] <= 1'b1;
            state             <= S_DRAIN_RD;
          end else if (FW'(scan_cnt + 1'b1) == fill) begin
            state <= S_EMIT;
          end else begin
            scan_slot <= scan_inc;
            scan_cnt  <= scan_cnt + 1'b1;
          end
        end
        S_DRAIN_RD: begin
          if (fill != '0 && stable[head]) begin
            state <= S_DRAIN_OUT;
          end else begin
            state <= S_EMIT;
          end
        end
        S_DRAIN_OUT: begin
          if (out_free) begin
            m_tuser      <= KIND_DELIVER;
            m_tdata      <= {4'b0000, qrd_data.payload, qrd_data.clock, qrd_data.origin};
            m_tlast      <= 1'b0;
            stable[head] <= 1'b0;
            head         <= head_inc;
            fill         <= fill - 1'b1;
            state        <= S_DRAIN_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tuser  <= res_kind;
            m_tdata  <= {4'b0000, res_payload, res_clock, res_origin};
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_empty_unstable: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (stable == '0))
    else $error("stable mark set in empty queue");

  a_deliver_not_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN_OUT && out_free) |=> (m_tvalid && !m_tlast && fill != FW'(QUEUE_DEPTH)))
    else $error("delivery result malformed");
`endif

endmodule

// ===== dv/tb_ring_total_order_broadcast_node.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_total_order_broadcast_node
// Checks the node against a cycle-free predictor of its clocks and pending
// queue. Directed broadcasts, data messages and acks come first, then
// random sequences of all actions, with acks mostly of queued entries,
// over several ring sizes and ranks, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_ring_total_order_broadcast_node;
  import rtob_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int QD = DEF_QUEUE_DEPTH;
  localparam int NS = DEF_MAX_SITES;
  localparam int SETTLE = 3 * QD + 40;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [RANK_W-1:0] snd;
    logic [CLK_W-1:0]  clk_v;
    logic [PAY_W-1:0]  pay;
    bit                from_q;
    bit                to_next;
  } item_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [RANK_W-1:0] org;
    logic [CLK_W-1:0]  clk_v;
    logic [PAY_W-1:0]  pay;
    logic              last;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic [ACT_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [KIND_W-1:0] m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [SC_W-1:0] cfg_data = '0;

  ring_total_order_broadcast_node dut (.*);

  always #1 clk = ~clk;

  item_t pending_items[$];
  res_t  expected_results[$];
  item_t cur_item;
  int    errors = 0;
  int    cyc = 0;

  // predicted node state
  logic [CLK_W-1:0]  site_clk[NS];
  logic [RANK_W-1:0] q_org[QD];
  logic [CLK_W-1:0]  q_clk[QD];
  logic [PAY_W-1:0]  q_pay[QD];
  bit                q_stb[QD];
  int                q_head, q_fill;
  logic [SC_W-1:0]   cfg_sites;
  logic [RANK_W-1:0] cfg_rank;

  function automatic logic [RANK_W-1:0] next_site();
    int n;
    n = cfg_sites;
    if (n == 0) n = 1;
    if (n > NS) n = NS;
    return RANK_W'((cfg_rank + 1) % n);
  endfunction

  function automatic void add_result(logic [KIND_W-1:0] k, logic [RANK_W-1:0] o,
                                     logic [CLK_W-1:0] c, logic [PAY_W-1:0] p);
    res_t r;
    r.kind = k; r.org = o; r.clk_v = c; r.pay = p; r.last = 1'b0;
    expected_results = {expected_results, r};
  endfunction

  function automatic void add_pending(item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic void enqueue(logic [RANK_W-1:0] o, logic [CLK_W-1:0] c,
                                  logic [PAY_W-1:0] p, bit s);
    int slot;
    slot = (q_head + q_fill) % QD;
    q_org[slot] = o; q_clk[slot] = c; q_pay[slot] = p; q_stb[slot] = s;
    q_fill++;
  endfunction

  function automatic void deliver_stable_run();
    while (q_fill > 0 && q_stb[q_head]) begin
      add_result(KIND_DELIVER, q_org[q_head], q_clk[q_head], q_pay[q_head]);
      q_stb[q_head] = 0;
      q_head = (q_head + 1) % QD;
      q_fill--;
    end
  endfunction

  function automatic void predict_item(item_t it);
    int slot;
    bit stable;
    if (it.act == ACT_LOCAL) begin
      if (q_fill >= QD) add_result(KIND_REFUSED, cfg_rank, '0, it.pay);
      else begin
        site_clk[cfg_rank] += 1;
        enqueue(cfg_rank, site_clk[cfg_rank], it.pay, 0);
        add_result(KIND_DATA, cfg_rank, site_clk[cfg_rank], it.pay);
      end
    end else if (it.act == ACT_DATA) begin
      if (q_fill >= QD) add_result(KIND_REFUSED, it.snd, it.clk_v, it.pay);
      else begin
        stable = (next_site() == it.snd);
        site_clk[it.snd] += 1;
        enqueue(it.snd, it.clk_v, it.pay, stable);
        if (stable) begin
          deliver_stable_run();
          add_result(KIND_ACK, it.snd, it.clk_v, it.pay);
        end else add_result(KIND_DATA, it.snd, it.clk_v, it.pay);
      end
    end else if (it.act == ACT_ACK) begin
      if (next_site() == it.snd) return;
      for (int i = 0; i < q_fill; i++) begin
        slot = (q_head + i) % QD;
        if (q_clk[slot] == it.clk_v && q_org[slot] == it.snd) begin
          q_stb[slot] = 1;
          deliver_stable_run();
          break;
        end
      end
      add_result(KIND_ACK, it.snd, it.clk_v, it.pay);
    end else return;
    expected_results[$].last = 1'b1;
  endfunction

  function automatic bit quiet_now();
    return (cyc >= 3000 && cyc < 6000);
  endfunction

  // driver
  always @(posedge clk) begin
    item_t nx;
    int i;
    cyc <= cyc + 1;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) predict_item(cur_item);
      if (pending_items.size() > 0 && (quiet_now() || $urandom_range(99) >= 37)) begin
        nx = pending_items.pop_front();
        if (nx.to_next) nx.snd = next_site();
        if (nx.from_q && q_fill > 0) begin
          i = (q_head + $urandom_range(q_fill - 1)) % QD;
          nx.snd = q_org[i];
          nx.clk_v = q_clk[i];
        end
        cur_item = nx;
        s_tdata <= {4'b0, nx.pay, nx.clk_v, nx.snd};
        s_tuser <= nx.act;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // monitor
  always @(posedge clk) begin
    res_t w;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report("unexpected transfer", m_tdata[63:0], 0);
        end else begin
          w = expected_results.pop_front();
          if (m_tuser !== w.kind) report("result_kind", m_tuser, w.kind);
          if (m_tdata[3:0] !== w.org) report("origin_rank", m_tdata[3:0], w.org);
          if (m_tdata[35:4] !== w.clk_v) report("out_clock", m_tdata[35:4], w.clk_v);
          if (m_tdata[67:36] !== w.pay) report("out_payload", m_tdata[67:36], w.pay);
          if (m_tdata[71:68] !== 4'b0) report("tdata pad", m_tdata[71:68], 0);
          if (m_tlast !== w.last) report("last", m_tlast, w.last);
        end
      end
      m_tready <= quiet_now() || ($urandom_range(99) >= 37);
    end
  end

  function automatic item_t make_item(logic [ACT_W-1:0] a, logic [RANK_W-1:0] s,
                                      logic [CLK_W-1:0] c, logic [PAY_W-1:0] p,
                                      bit fq, bit tn);
    item_t it;
    it.act = a; it.snd = s; it.clk_v = c; it.pay = p; it.from_q = fq; it.to_next = tn;
    return it;
  endfunction

  function automatic item_t random_item();
    int r;
    r = $urandom_range(99);
    if (r < 30)
      return make_item(ACT_LOCAL, RANK_W'($urandom), $urandom, $urandom, 1'b0, 1'b0);
    if (r < 55)
      return make_item(ACT_DATA, RANK_W'($urandom), $urandom, $urandom, 1'b0,
                       $urandom_range(2) == 0);
    if (r < 95)
      return make_item(ACT_ACK, RANK_W'($urandom), $urandom, $urandom,
                       $urandom_range(9) < 8, $urandom_range(9) == 0);
    return make_item(ACT_UNUSED, RANK_W'($urandom), $urandom, $urandom, 1'b0, 1'b0);
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [SC_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SITE_COUNT) cfg_sites = val;
    else cfg_rank = val[RANK_W-1:0];
  endtask

  logic [SC_W-1:0] phase_sites[7] = '{5'd4, 5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd2};
  logic [SC_W-1:0] phase_rank[7]  = '{5'd1, 5'd15, 5'd0, 5'd6, 5'h1f, 5'd7, 5'd0};

  initial begin
    for (int i = 0; i < NS; i++) site_clk[i] = '0;
    for (int i = 0; i < QD; i++) q_stb[i] = 0;
    q_head = 0; q_fill = 0;
    cfg_sites = 5'd1; cfg_rank = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_SITE_COUNT, phase_sites[ph]);
      write_reg(REG_OWN_RANK, phase_rank[ph]);
      if (ph == 0) begin
        // ring of 4, rank 1, next site 2
        add_pending(make_item(ACT_LOCAL, '0, '0, 32'h0, 1'b0, 1'b0));
        add_pending(make_item(ACT_LOCAL, 4'hf, '1, '1, 1'b0, 1'b0));
        add_pending(make_item(ACT_DATA, 4'd2, 32'h0, 32'h11, 1'b0, 1'b0));
        add_pending(make_item(ACT_DATA, 4'd15, '1, 32'h22, 1'b0, 1'b0));
        add_pending(make_item(ACT_DATA, 4'd0, 32'h0, '1, 1'b0, 1'b0));
        add_pending(make_item(ACT_ACK, 4'd1, 32'd1, 32'h33, 1'b0, 1'b0));
        add_pending(make_item(ACT_ACK, 4'd2, 32'd0, 32'h44, 1'b0, 1'b0));
        add_pending(make_item(ACT_ACK, 4'd3, 32'h1234, 32'h55, 1'b0, 1'b0));
        add_pending(make_item(ACT_UNUSED, 4'd1, '1, '1, 1'b0, 1'b0));
        add_pending(make_item(ACT_ACK, 4'd15, '1, 32'h66, 1'b0, 1'b0));
        add_pending(make_item(ACT_ACK, 4'd1, 32'd2, 32'h77, 1'b0, 1'b0));
        add_pending(make_item(ACT_ACK, 4'd0, 32'h0, 32'h88, 1'b0, 1'b0));
        for (int i = 0; i < 34; i++)
          add_pending(make_item(ACT_LOCAL, '0, '0, $urandom, 1'b0, 1'b0));
        add_pending(make_item(ACT_DATA, 4'd5, '1, 32'h99, 1'b0, 1'b0));
        add_pending(make_item(ACT_DATA, 4'd2, '1, 32'haa, 1'b0, 1'b0));
      end
      for (int i = 0; i < 62; i++) add_pending(random_item());
      wait_idle();
    end
    if (errors == 0) $display("ring_total_order_broadcast_node test passed");
    else $display("ring_total_order_broadcast_node test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("ring_total_order_broadcast_node test failed");
    $finish;
  end

endmodule
